@@ rtl/core/pwts_pkg.sv @@
// Package with the constants, types and helper functions of the projection block.
package pwts_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int NB        = DW + FRAC_BITS;
    localparam int NDC_W     = 49;
    localparam int ADDR_W    = 6;
    localparam int SIZE_W    = 14;

    localparam logic signed [63:0] ONE_FX    = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] W_MIN_FX  = 32'((2 ** FRAC_BITS + 99) / 100);
    localparam logic signed [63:0] NDC_LIMIT = 64'sd1 <<< 47;
    localparam logic signed [63:0] S32_MAX   = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN   = -64'sd2147483648;

    typedef enum logic [2:0] {
        REG_ROW0_LEFT  = 3'd0,
        REG_ROW0_RIGHT = 3'd1,
        REG_ROW1_LEFT  = 3'd2,
        REG_ROW1_RIGHT = 3'd3,
        REG_ROW3_LEFT  = 3'd4,
        REG_ROW3_RIGHT = 3'd5,
        REG_WIDTH      = 3'd6,
        REG_HEIGHT     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][63:0]   left;
        logic [2:0][63:0]   right;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } t_cfg;

    typedef struct packed {
        logic          vis;
        logic          negx;
        logic          negy;
        logic [NB-1:0] qx;
        logic [NB-1:0] qy;
        logic [DW-1:0] rx;
        logic [DW-1:0] ry;
    } t_quo;

    function automatic logic signed [31:0] f_entry(t_cfg c, int r, int k);
        logic [63:0] word;
        word = (k < 2) ? c.left[r] : c.right[r];
        return (k % 2 == 0) ? $signed(word[31:0]) : $signed(word[63:32]);
    endfunction

    function automatic logic signed [31:0] f_sat32(logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > S32_MAX) begin
            res = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/pwts_if.sv @@
// Stream interfaces for world points and screen results.
interface pwts_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    modport source (output valid, output world_x, output world_y, output world_z, input ready);
    modport sink   (input valid, input world_x, input world_y, input world_z, output ready);
endinterface

interface pwts_out_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    modport source (output valid, output visible, output screen_x, output screen_y, input ready);
    modport sink   (input valid, input visible, input screen_x, input screen_y, output ready);
endinterface

@@ rtl/core/pwts_dot.sv @@
// Matrix rows times world point: product stage and sum/saturate stage.
module pwts_dot import pwts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic signed [31:0] o_cx,
    output logic signed [31:0] o_cy,
    output logic signed [31:0] o_w
);

    logic signed [63:0] r_p [3][3];
    logic signed [31:0] r_e3 [3];
    logic               r_v1;
    logic               r_v2;
    logic signed [31:0] r_clip [3];
    logic signed [31:0] c [3];
    logic signed [63:0] n_acc [3];

    assign c[0] = i_x;
    assign c[1] = i_y;
    assign c[2] = i_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_p[r][k] <= 64'(f_entry(i_cfg, r, k)) * 64'(c[k]);
                end
                r_e3[r] <= f_entry(i_cfg, r, 3);
            end
        end
    end

    // The floor to the fixed-point grid is an arithmetic shift of each product.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_acc[r] = (r_p[r][0] >>> FRAC_BITS) + (r_p[r][1] >>> FRAC_BITS)
                     + (r_p[r][2] >>> FRAC_BITS) + 64'(r_e3[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_clip[r] <= f_sat32(n_acc[r]);
            end
        end
    end

    assign o_valid = r_v2;
    assign o_cx    = r_clip[0];
    assign o_cy    = r_clip[1];
    assign o_w     = r_clip[2];

endmodule

@@ rtl/core/pwts_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for both clip axes.
module pwts_div import pwts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_cx,
    input  logic signed [31:0] i_cy,
    input  logic signed [31:0] i_w,
    output logic               o_valid,
    output t_quo               o_quo
);

    logic          r_v    [NB+1];
    logic          r_vis  [NB+1];
    logic          r_negx [NB+1];
    logic          r_negy [NB+1];
    logic [DW-1:0] r_d    [NB+1];
    logic [NB-1:0] r_nqx  [NB+1];
    logic [NB-1:0] r_nqy  [NB+1];
    logic [DW-1:0] r_remx [NB+1];
    logic [DW-1:0] r_remy [NB+1];

    logic signed [NB-1:0] n_numx;
    logic signed [NB-1:0] n_numy;

    assign n_numx = NB'(i_cx) <<< FRAC_BITS;
    assign n_numy = NB'(i_cy) <<< FRAC_BITS;

    // Setup stage: visibility test and the numerator magnitudes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vis[0]  <= (i_w >= W_MIN_FX);
            r_negx[0] <= n_numx[NB-1];
            r_negy[0] <= n_numy[NB-1];
            r_d[0]    <= i_w;
            r_nqx[0]  <= n_numx[NB-1] ? NB'(-n_numx) : n_numx;
            r_nqy[0]  <= n_numy[NB-1] ? NB'(-n_numy) : n_numy;
            r_remx[0] <= '0;
            r_remy[0] <= '0;
        end
    end

    // Each stage shifts one numerator bit into the remainder and the
    // quotient bit into the vacated low end of the numerator register.
    for (genvar i = 1; i <= NB; i++) begin : g_stage
        logic [DW-1:0] n_tx;
        logic [DW-1:0] n_ty;
        logic          n_gex;
        logic          n_gey;

        assign n_tx  = {r_remx[i-1][DW-2:0], r_nqx[i-1][NB-1]};
        assign n_ty  = {r_remy[i-1][DW-2:0], r_nqy[i-1][NB-1]};
        assign n_gex = (n_tx >= r_d[i-1]);
        assign n_gey = (n_ty >= r_d[i-1]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else if (i_en) begin
                r_v[i] <= r_v[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vis[i]  <= r_vis[i-1];
                r_negx[i] <= r_negx[i-1];
                r_negy[i] <= r_negy[i-1];
                r_d[i]    <= r_d[i-1];
                r_remx[i] <= n_gex ? n_tx - r_d[i-1] : n_tx;
                r_remy[i] <= n_gey ? n_ty - r_d[i-1] : n_ty;
                r_nqx[i]  <= {r_nqx[i-1][NB-2:0], n_gex};
                r_nqy[i]  <= {r_nqy[i-1][NB-2:0], n_gey};
            end
        end
    end

    assign o_valid     = r_v[NB];
    assign o_quo.vis   = r_vis[NB];
    assign o_quo.negx  = r_negx[NB];
    assign o_quo.negy  = r_negy[NB];
    assign o_quo.qx    = r_nqx[NB];
    assign o_quo.qy    = r_nqy[NB];
    assign o_quo.rx    = r_remx[NB];
    assign o_quo.ry    = r_remy[NB];

endmodule

@@ rtl/core/pwts_map.sv @@
// Quotient sign fix and clamp, scale by screen size, then pixel offset and saturation.
module pwts_map import pwts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_quo               i_quo,
    input  t_cfg               i_cfg,
    output logic               o_valid,
    output logic               o_visible,
    output logic signed [31:0] o_sx,
    output logic signed [31:0] o_sy
);

    logic                    r_v   [3];
    logic                    r_vis [3];
    logic signed [NDC_W-1:0] r_ndcx;
    logic signed [NDC_W-1:0] r_ndcy;
    logic signed [63:0]      r_px;
    logic signed [63:0]      r_py;
    logic signed [31:0]      r_sx;
    logic signed [31:0]      r_sy;

    logic signed [63:0] n_qx;
    logic signed [63:0] n_qy;
    logic signed [63:0] n_cx;
    logic signed [63:0] n_cy;
    logic signed [63:0] n_bx;
    logic signed [63:0] n_by;
    logic signed [63:0] n_hx;
    logic signed [63:0] n_hy;

    // Floor division of a negative numerator rounds the magnitude up.
    always_comb begin
        n_qx = $signed(64'(i_quo.qx));
        n_qy = $signed(64'(i_quo.qy));
        if (i_quo.negx) begin
            n_qx = -(n_qx + $signed(64'(|i_quo.rx)));
        end
        if (i_quo.negy) begin
            n_qy = -(n_qy + $signed(64'(|i_quo.ry)));
        end
        n_cx = (n_qx > NDC_LIMIT) ? NDC_LIMIT : ((n_qx < -NDC_LIMIT) ? -NDC_LIMIT : n_qx);
        n_cy = (n_qy > NDC_LIMIT) ? NDC_LIMIT : ((n_qy < -NDC_LIMIT) ? -NDC_LIMIT : n_qy);
        n_bx = $signed(64'(i_cfg.width[SIZE_W-1:1])) <<< FRAC_BITS;
        n_by = $signed(64'(i_cfg.height[SIZE_W-1:1])) <<< FRAC_BITS;
        n_hx = r_px >>> 1;
        n_hy = r_py >>> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
            r_v[2] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vis[0] <= i_quo.vis;
            r_vis[1] <= r_vis[0];
            r_vis[2] <= r_vis[1];
            r_ndcx   <= n_cx[NDC_W-1:0];
            r_ndcy   <= n_cy[NDC_W-1:0];
            r_px     <= r_ndcx * $signed({1'b0, i_cfg.width}) + ONE_FX;
            r_py     <= r_ndcy * $signed({1'b0, i_cfg.height}) + ONE_FX;
            r_sx     <= r_vis[1] ? f_sat32(n_bx + n_hx) : '0;
            r_sy     <= r_vis[1] ? f_sat32(n_by - n_hy) : '0;
        end
    end

    assign o_valid   = r_v[2];
    assign o_visible = r_vis[2];
    assign o_sx      = r_sx;
    assign o_sy      = r_sy;

endmodule

@@ rtl/core/perspective_world_to_screen_top.sv @@
// Top level of the perspective world-to-screen projection pipeline.
//
// Usage: world points arrive on the i_pt stream (world_x, world_y, world_z,
// signed Q16.16) and one result word per point leaves on the o_px stream
// (visible, screen_x, screen_y). A word moves when valid and ready are both
// high at a rising clock edge. The view matrix rows 0, 1 and 3 and the screen
// size are written over the APB port, 64-bit registers at byte address 8*i;
// they must only be changed while no point is in flight.
//
// From acceptance to the result word a point passes the product register,
// the sum register, the divider setup register, the restoring divider's
// quotient-bit stages (48 bits) and the sign fix, scaling and final offset
// registers. The pipeline takes one point every cycle while the receiver
// does not stall; the divider chain sets the latency, not the rate.
//
// When the receiver stalls, the whole pipeline holds in place and the input
// ready drops, so no word is lost or repeated. Bubbles inside the pipeline
// are not squeezed out while it is held.
// Reset (synchronous, active low) clears every valid bit, zeroes the matrix
// and sets the screen to 1920 by 1080.
module perspective_world_to_screen_top import pwts_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pwts_in_if.sink           i_pt,
    pwts_out_if.source        o_px,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    t_cfg               r_cfg;
    logic               w_en;
    logic               w_dot_v;
    logic signed [31:0] w_cx;
    logic signed [31:0] w_cy;
    logic signed [31:0] w_w;
    logic               w_div_v;
    t_quo               w_quo;
    t_reg_idx           w_idx;

    // The pipeline moves whenever the output register is empty or being read.
    assign w_en       = !o_px.valid || o_px.ready;
    assign i_pt.ready = w_en;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left   <= '0;
            r_cfg.right  <= '0;
            r_cfg.width  <= SIZE_W'(1920);
            r_cfg.height <= SIZE_W'(1080);
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_ROW0_LEFT:  r_cfg.left[0]  <= pwdata;
                REG_ROW0_RIGHT: r_cfg.right[0] <= pwdata;
                REG_ROW1_LEFT:  r_cfg.left[1]  <= pwdata;
                REG_ROW1_RIGHT: r_cfg.right[1] <= pwdata;
                REG_ROW3_LEFT:  r_cfg.left[2]  <= pwdata;
                REG_ROW3_RIGHT: r_cfg.right[2] <= pwdata;
                REG_WIDTH:      r_cfg.width    <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:     r_cfg.height   <= pwdata[SIZE_W-1:0];
                default:        r_cfg.width    <= r_cfg.width;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ROW0_LEFT:  prdata = r_cfg.left[0];
            REG_ROW0_RIGHT: prdata = r_cfg.right[0];
            REG_ROW1_LEFT:  prdata = r_cfg.left[1];
            REG_ROW1_RIGHT: prdata = r_cfg.right[1];
            REG_ROW3_LEFT:  prdata = r_cfg.left[2];
            REG_ROW3_RIGHT: prdata = r_cfg.right[2];
            REG_WIDTH:      prdata = 64'(r_cfg.width);
            REG_HEIGHT:     prdata = 64'(r_cfg.height);
            default:        prdata = '0;
        endcase
    end

    pwts_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_pt.valid),
        .i_x     (i_pt.world_x),
        .i_y     (i_pt.world_y),
        .i_z     (i_pt.world_z),
        .i_cfg   (r_cfg),
        .o_valid (w_dot_v),
        .o_cx    (w_cx),
        .o_cy    (w_cy),
        .o_w     (w_w)
    );

    pwts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dot_v),
        .i_cx    (w_cx),
        .i_cy    (w_cy),
        .i_w     (w_w),
        .o_valid (w_div_v),
        .o_quo   (w_quo)
    );

    pwts_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_div_v),
        .i_quo     (w_quo),
        .i_cfg     (r_cfg),
        .o_valid   (o_px.valid),
        .o_visible (o_px.visible),
        .o_sx      (o_px.screen_x),
        .o_sy      (o_px.screen_y)
    );

endmodule

@@ rtl/core/pwts_chk.sv @@
// Port-level checker for the projection block and its bind.
module pwts_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_visible,
    input logic [31:0] i_sx,
    input logic [31:0] i_sy
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result word present right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_sx) && $stable(i_sy) && $stable(i_visible))
        else $error("result word changed while stalled");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while the full pipeline is stalled");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_visible |-> (i_sx == 32'd0) && (i_sy == 32'd0))
        else $error("hidden point with nonzero screen position");

endmodule

bind perspective_world_to_screen_top pwts_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_px.valid),
    .i_out_ready (o_px.ready),
    .i_visible   (o_px.visible),
    .i_sx        (o_px.screen_x),
    .i_sy        (o_px.screen_y)
);

@@ dv/perspective_world_to_screen_top_test.sv @@
// Self-checking testbench for the perspective world-to-screen projection block.
`timescale 1ns / 100ps

module perspective_world_to_screen_top_test;
    import pwts_pkg::*;

    // Cycles without any accepted word before the run is declared hung.
    // This is far above the pipeline latency and any honest gap: drains,
    // register writes and long receiver stalls included.
    localparam int HANG_LIMIT = 5000;
    // A little more than the acceptance-to-result latency of the pipeline.
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        logic               vis;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    pwts_in_if  pt_if ();
    pwts_out_if px_if ();

    perspective_world_to_screen_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_px    (px_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the configuration that the predictor works from.
    logic [63:0]       mat_left [3];
    logic [63:0]       mat_right[3];
    logic [SIZE_W-1:0] scr_w;
    logic [SIZE_W-1:0] scr_h;

    // Projected pixels that are still owed by the block, oldest first.
    t_pixel pending_pixels[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned error_count;
    int unsigned quiet_cycles;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Projection predictor. Products are exact and then floored back to
    // the fraction width, which for a power of two is an arithmetic shift.
    // ---------------------------------------------------------------
    function automatic longint floor_quot(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint clamp32(longint v);
        longint r;
        r = v;
        if (v > S32_MAX) begin
            r = S32_MAX;
        end else if (v < S32_MIN) begin
            r = S32_MIN;
        end
        return r;
    endfunction

    function automatic longint row_clip(int r, longint x, longint y, longint z);
        longint e0, e1, e2, e3, acc;
        e0 = longint'($signed(mat_left[r][31:0]));
        e1 = longint'($signed(mat_left[r][63:32]));
        e2 = longint'($signed(mat_right[r][31:0]));
        e3 = longint'($signed(mat_right[r][63:32]));
        acc = ((e0 * x) >>> FRAC_BITS) + ((e1 * y) >>> FRAC_BITS)
            + ((e2 * z) >>> FRAC_BITS) + e3;
        return clamp32(acc);
    endfunction

    // Half of the normalized offset scaled to pixels, plus half a pixel.
    function automatic longint pixel_offset(longint clip, longint w, longint size);
        longint ndc;
        ndc = floor_quot(clip <<< FRAC_BITS, w);
        if (ndc > NDC_LIMIT) begin
            ndc = NDC_LIMIT;
        end else if (ndc < -NDC_LIMIT) begin
            ndc = -NDC_LIMIT;
        end
        return (ndc * size + ONE_FX) >>> 1;
    endfunction

    function automatic t_pixel project_point(logic [31:0] wx, logic [31:0] wy,
                                             logic [31:0] wz);
        longint x, y, z, cx, cy, cw, sx, sy;
        t_pixel px;
        x  = longint'($signed(wx));
        y  = longint'($signed(wy));
        z  = longint'($signed(wz));
        cx = row_clip(0, x, y, z);
        cy = row_clip(1, x, y, z);
        cw = row_clip(2, x, y, z);
        px = '0;
        // Points too close to or behind the eye come back invisible at zero.
        if (cw >= longint'(W_MIN_FX)) begin
            sx = longint'(scr_w / 2) * ONE_FX + pixel_offset(cx, cw, longint'(scr_w));
            sy = longint'(scr_h / 2) * ONE_FX - pixel_offset(cy, cw, longint'(scr_h));
            px.vis = 1'b1;
            px.sx  = 32'(clamp32(sx));
            px.sy  = 32'(clamp32(sy));
        end
        return px;
    endfunction

    // ---------------------------------------------------------------
    // Receiver side: random back-pressure and the result checker.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        px_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && px_if.valid && px_if.ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected word vis=%0b x=%h y=%h", $time,
                         px_if.visible, px_if.screen_x, px_if.screen_y);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (px_if.visible !== want.vis) begin
                    $display("%0t: visible expected %0b actual %0b", $time,
                             want.vis, px_if.visible);
                    error_count++;
                end
                if (px_if.screen_x !== want.sx) begin
                    $display("%0t: screen_x expected %h actual %h", $time,
                             want.sx, px_if.screen_x);
                    error_count++;
                end
                if (px_if.screen_y !== want.sy) begin
                    $display("%0t: screen_y expected %h actual %h", $time,
                             want.sy, px_if.screen_y);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any accepted word on either stream counts as progress.
    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (px_if.valid && px_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sender and register tasks.
    // ---------------------------------------------------------------

    // Offers one world point, possibly after a random gap, and records the
    // pixel it must produce once the word is taken. Valid stays high for
    // back-to-back words and is only lowered inside a gap.
    task automatic send_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.world_x <= wx;
        pt_if.world_y <= wy;
        pt_if.world_z <= wz;
        do begin
            @(posedge i_clk);
        end while (!pt_if.ready);
        pending_pixels.push_back(project_point(wx, wy, wz));
    endtask

    // Stops sending and waits until every owed pixel has arrived, plus the
    // pipeline latency so the block is truly idle.
    task automatic drain_pipeline();
        pt_if.valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW0_LEFT:  mat_left[0]  = value;
            REG_ROW0_RIGHT: mat_right[0] = value;
            REG_ROW1_LEFT:  mat_left[1]  = value;
            REG_ROW1_RIGHT: mat_right[1] = value;
            REG_ROW3_LEFT:  mat_left[2]  = value;
            REG_ROW3_RIGHT: mat_right[2] = value;
            REG_WIDTH:      scr_w        = value[SIZE_W-1:0];
            REG_HEIGHT:     scr_h        = value[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Loads one view matrix; each argument is one entry in Q16.16.
    task automatic load_matrix(logic [31:0] a00, logic [31:0] a01, logic [31:0] a02,
                               logic [31:0] a03, logic [31:0] a10, logic [31:0] a11,
                               logic [31:0] a12, logic [31:0] a13, logic [31:0] a30,
                               logic [31:0] a31, logic [31:0] a32, logic [31:0] a33);
        write_reg(REG_ROW0_LEFT,  {a01, a00});
        write_reg(REG_ROW0_RIGHT, {a03, a02});
        write_reg(REG_ROW1_LEFT,  {a11, a10});
        write_reg(REG_ROW1_RIGHT, {a13, a12});
        write_reg(REG_ROW3_LEFT,  {a31, a30});
        write_reg(REG_ROW3_RIGHT, {a33, a32});
    endtask

    // Signed value in [-span, span] on the Q16.16 grid.
    function automatic logic [31:0] rand_fx(int unsigned span);
        return 32'($signed({1'b0, $urandom_range(2 * span, 0)}) - $signed({1'b0, span}));
    endfunction

    function automatic logic [13:0] rand_size();
        logic [13:0] s;
        case ($urandom_range(5))
            0:       s = 14'd1;
            1:       s = 14'd8192;
            2:       s = 14'd0;
            3:       s = 14'h3FFF;
            default: s = 14'($urandom_range(8192, 1));
        endcase
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------

    // After reset the matrix is zero, so w is zero and nothing is visible.
    task automatic test_reset_invisible();
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
        send_point(32'h80000000, 32'h7FFFFFFF, 32'h00010000);
        drain_pipeline();
    endtask

    // w sits exactly at the 0.01 threshold: one raw step below is hidden.
    task automatic test_visibility_edge();
        load_matrix(32'h00010000, 0, 0, 0, 0, 32'h00010000, 0, 0,
                    0, 0, 0, W_MIN_FX - 1);
        send_point(32'h00010000, 32'h00010000, 32'h0);
        drain_pipeline();
        write_reg(REG_ROW3_RIGHT, {W_MIN_FX, 32'h0});
        send_point(32'h00010000, 32'h00010000, 32'h0);
        send_point(32'hFFFF0000, 32'h00008000, 32'h0);
        drain_pipeline();
        // Negative w, the point is behind the eye.
        write_reg(REG_ROW3_RIGHT, {32'hFFFF0000, 32'h0});
        send_point(32'h00010000, 32'h0, 32'h0);
        drain_pipeline();
    endtask

    // Identity-style projection with w = z, covering field extremes,
    // saturation, the normalized-offset clamp and the screen size corners.
    task automatic test_field_extremes();
        logic [13:0] sizes[4];
        sizes = '{14'd1, 14'd8192, 14'd0, 14'h3FFF};
        load_matrix(32'h00010000, 0, 0, 0, 0, 32'h00010000, 0, 0,
                    0, 0, 32'h00010000, 0);
        foreach (sizes[i]) begin
            write_reg(REG_WIDTH,  {50'h0, sizes[i]});
            write_reg(REG_HEIGHT, {50'h0, sizes[3 - i]});
            send_point(32'h0, 32'h0, 32'h00010000);
            send_point(32'h7FFFFFFF, 32'h80000000, 32'h00010000);
            send_point(32'h80000000, 32'h7FFFFFFF, W_MIN_FX);
            send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
            drain_pipeline();
        end
        write_reg(REG_WIDTH,  64'd1920);
        write_reg(REG_HEIGHT, 64'd1080);
        // Full-range entries push the clip sums into saturation.
        load_matrix(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h00000001, 0, 0, 32'h7FFFFFFF);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'h00010000, 32'hFFFF0000, 32'h0);
        drain_pipeline();
    endtask

    // Random cameras and points. Most matrices keep w positive so the
    // divider path is exercised; some are fully random.
    task automatic test_random_projection(int unsigned n_points, int unsigned n_cameras);
        logic [31:0] wx, wy, wz;
        for (int c = 0; c < n_cameras; c++) begin
            drain_pipeline();
            if ($urandom_range(3) == 0) begin
                load_matrix($urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom);
            end else begin
                load_matrix(rand_fx(32'h20000), rand_fx(32'h20000), rand_fx(32'h20000),
                            rand_fx(32'h400000), rand_fx(32'h20000), rand_fx(32'h20000),
                            rand_fx(32'h20000), rand_fx(32'h400000),
                            rand_fx(32'h1800), rand_fx(32'h1800), rand_fx(32'h1800),
                            32'($urandom_range(32'h320000, 32'h100)));
            end
            write_reg(REG_WIDTH,  {50'h0, rand_size()});
            write_reg(REG_HEIGHT, {50'h0, rand_size()});
            for (int i = 0; i < n_points / n_cameras; i++) begin
                if ($urandom_range(3) == 0) begin
                    wx = $urandom;
                    wy = $urandom;
                    wz = $urandom;
                end else begin
                    wx = rand_fx(32'h640000);
                    wy = rand_fx(32'h640000);
                    wz = rand_fx(32'h640000);
                end
                send_point(wx, wy, wz);
                // Once per camera the sender holds back until the pipeline
                // has handed over everything it owes.
                if (i == n_points / (2 * n_cameras)) begin
                    pt_if.valid <= 1'b0;
                    wait (pending_pixels.size() == 0);
                end
            end
        end
        drain_pipeline();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        pt_if.valid    = 1'b0;
        pt_if.world_x  = '0;
        pt_if.world_y  = '0;
        pt_if.world_z  = '0;
        px_if.ready    = 1'b0;
        send_idle_pct  = 12;
        recv_stall_pct = 52;
        error_count    = 0;
        quiet_cycles   = 0;
        foreach (mat_left[r]) begin
            mat_left[r]  = '0;
            mat_right[r] = '0;
        end
        scr_w = 14'd1920;
        scr_h = 14'd1080;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_invisible();
        test_visibility_edge();
        test_field_extremes();

        test_random_projection(170, 4);
        send_idle_pct  = 52;
        recv_stall_pct = 12;
        test_random_projection(170, 4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_projection(170, 4);

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
